FILE: rtl/acal_pkg.sv
// Shared types and constants for the analog axis calibrator.
`default_nettype none
package acal_pkg;

	localparam int AXIS_W     = 16;
	localparam int DZ_W       = 8;
	localparam int RECIP_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int DIV_STEPS  = 17;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic [AXIS_W-1:0]  AXIS_MAX = '1;
	localparam logic [RECIP_W-1:0] DIVIDEND = RECIP_W'(1) << AXIS_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_BAND = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_AXIS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_CALIBRATE  = 3'd4;

	localparam logic [DZ_W-1:0] DZ_LOW_RESET  = 8'd12;
	localparam logic [DZ_W-1:0] DZ_HIGH_RESET = 8'd242;
	localparam logic [DZ_W-1:0] BAND_RESET    = 8'd1;

	typedef struct packed {
		logic [DZ_W-1:0] deadzone_low;
		logic [DZ_W-1:0] deadzone_high;
		logic [DZ_W-1:0] hysteresis_band;
		logic            invert_axis;
		logic            auto_calibrate;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILTER,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SPAN,
		ST_DIV,
		ST_MAP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic filter;
		logic mul_lo;
		logic mul_hi;
		logic div_start;
		logic map;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_cmd;
		logic extreme;
		logic span_ok;
		logic div_done;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/acal_sample_if.sv
// Input channel: command and raw converter sample.
`default_nettype none
interface acal_sample_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [SAMPLE_BITS-1:0] raw_sample;

	modport source (output valid, output command, output raw_sample, input ready);
	modport sink   (input valid, input command, input raw_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/acal_result_if.sv
// Output channel: mapped position and calibration extremes.
`default_nettype none
interface acal_result_if;
	logic                        valid;
	logic                        ready;
	logic [acal_pkg::AXIS_W-1:0] position;
	logic [acal_pkg::AXIS_W-1:0] calib_low;
	logic [acal_pkg::AXIS_W-1:0] calib_high;

	modport source (output valid, output position, output calib_low, output calib_high,
		input ready);
	modport sink   (input valid, input position, input calib_low, input calib_high,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/acal_div.sv
// Restoring serial divider: 65536 / divisor, one quotient bit per cycle.
`default_nettype none
module acal_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [acal_pkg::AXIS_W-1:0]  divisor,
	output logic                              done,
	output logic [acal_pkg::RECIP_W-1:0]      quotient
);
	logic                            busy_q;
	logic                            done_q;
	logic [acal_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [acal_pkg::AXIS_W-1:0]     d_q;
	logic [acal_pkg::AXIS_W-1:0]     rem_q;
	logic [acal_pkg::RECIP_W-1:0]    quo_q;
	logic [acal_pkg::AXIS_W:0]       trial;
	logic                            fits;

	assign trial = {rem_q, quo_q[acal_pkg::RECIP_W-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= acal_pkg::DIV_CNT_W'(acal_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == acal_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= divisor;
			rem_q <= '0;
			quo_q <= acal_pkg::DIVIDEND;
		end else if (busy_q) begin
			rem_q <= fits ? acal_pkg::AXIS_W'(trial - {1'b0, d_q})
			              : acal_pkg::AXIS_W'(trial);
			quo_q <= {quo_q[acal_pkg::RECIP_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	// quotient never overshoots 65536 / divisor
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((33'(quo_q) * 33'(d_q)) <= 33'(acal_pkg::DIVIDEND)))
		else $error("divider quotient too large");

endmodule
`default_nettype wire

FILE: rtl/acal_dp.sv
// Datapath: filter, extremes, domain, reciprocal and output register.
`default_nettype none
module acal_dp #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire acal_pkg::cfg_t              cfg,
	input  wire acal_pkg::cmd_t              cmd,
	output acal_pkg::status_t                status,
	input  wire logic                        in_command,
	input  wire logic [SAMPLE_BITS-1:0]      in_raw,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [acal_pkg::AXIS_W-1:0]      out_position,
	output logic [acal_pkg::AXIS_W-1:0]      out_calib_low,
	output logic [acal_pkg::AXIS_W-1:0]      out_calib_high
);
	localparam int W = acal_pkg::AXIS_W;
	localparam int DZ_SEL_W = 1;

	logic                         command_q;
	logic [SAMPLE_BITS-1:0]       raw_q;
	logic [W-1:0]                 filt_q;
	logic [W-1:0]                 axis_q;
	logic [W-1:0]                 seen_low_q;
	logic [W-1:0]                 seen_high_q;
	logic [W-1:0]                 start_q;
	logic [W-1:0]                 end_q;
	logic [acal_pkg::RECIP_W-1:0] recip_q;
	logic [W-1:0]                 pos_q;
	logic                         out_valid_q;
	logic [W-1:0]                 out_pos_q;
	logic [W-1:0]                 out_low_q;
	logic [W-1:0]                 out_high_q;

	logic [W-1:0]                 raw16;
	logic [W:0]                   upper_lim;
	logic [W:0]                   raw_plus;
	logic [W-1:0]                 filt_nxt;
	logic [W-1:0]                 axis_nxt;
	logic                         new_low;
	logic                         new_high;
	logic [W-1:0]                 range;
	logic [DZ_SEL_W-1:0]          unused_sel;
	logic [W+acal_pkg::DZ_W-1:0]  mprod;
	logic [W-1:0]                 bound;
	logic [W-1:0]                 diff;
	logic [2*W-1:0]               map_prod;
	logic                         div_done;
	logic [acal_pkg::RECIP_W-1:0] div_quo;

	// hysteresis filter, widened by one bit so the band never wraps
	assign raw16     = W'(raw_q);
	assign upper_lim = {1'b0, filt_q} + (W+1)'(cfg.hysteresis_band);
	assign raw_plus  = {1'b0, raw16} + (W+1)'(cfg.hysteresis_band);

	always_comb begin
		if ({1'b0, raw16} > upper_lim)
			filt_nxt = raw16 - W'(cfg.hysteresis_band);
		else if (raw_plus < {1'b0, filt_q})
			filt_nxt = W'(raw_plus);
		else
			filt_nxt = filt_q;
	end

	assign axis_nxt = cfg.invert_axis ? ~filt_nxt : filt_nxt;
	assign new_low  = cfg.auto_calibrate && (axis_nxt < seen_low_q);
	assign new_high = cfg.auto_calibrate && (axis_nxt > seen_high_q);

	// one shared 16x8 multiplier for both deadzone edges
	assign unused_sel = DZ_SEL_W'(cmd.mul_hi);
	assign range      = seen_high_q - seen_low_q;
	assign mprod      = (W+acal_pkg::DZ_W)'(range) *
	                    (W+acal_pkg::DZ_W)'(unused_sel[0] ? cfg.deadzone_high
	                                                      : cfg.deadzone_low);
	assign bound      = seen_low_q + mprod[W+acal_pkg::DZ_W-1:acal_pkg::DZ_W];

	assign diff     = axis_q - start_q;
	assign map_prod = (2*W)'(diff) * (2*W)'(recip_q[W-1:0]);

	acal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (end_q - start_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			command_q <= in_command;
			raw_q     <= in_raw;
		end
		if (cmd.filter)
			axis_q <= axis_nxt;
		if (cmd.map) begin
			if (axis_q <= start_q)
				pos_q <= '0;
			else if (axis_q >= end_q)
				pos_q <= acal_pkg::AXIS_MAX;
			else
				pos_q <= map_prod[W-1:0];
		end
		if (cmd.out_load) begin
			out_pos_q  <= pos_q;
			out_low_q  <= seen_low_q;
			out_high_q <= seen_high_q;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q      <= '0;
			seen_low_q  <= acal_pkg::AXIS_MAX;
			seen_high_q <= '0;
			start_q     <= acal_pkg::AXIS_MAX;
			end_q       <= acal_pkg::AXIS_MAX;
			recip_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.filter) begin
				if (command_q) begin
					// recalibrate: empty span always lands on an empty domain at the top
					filt_q      <= raw16;
					seen_low_q  <= acal_pkg::AXIS_MAX;
					seen_high_q <= '0;
					start_q     <= acal_pkg::AXIS_MAX;
					end_q       <= acal_pkg::AXIS_MAX;
				end else begin
					filt_q <= filt_nxt;
					if (new_low)
						seen_low_q <= axis_nxt;
					if (new_high)
						seen_high_q <= axis_nxt;
				end
			end
			if (cmd.mul_lo)
				start_q <= bound;
			if (cmd.mul_hi)
				end_q <= bound;
			if (div_done)
				recip_q <= div_quo;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status          = '0;
		status.is_cmd   = command_q;
		status.extreme  = new_low || new_high;
		status.span_ok  = end_q > start_q;
		status.div_done = div_done;
		status.out_free = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign out_position   = out_pos_q;
	assign out_calib_low  = out_low_q;
	assign out_calib_high = out_high_q;

	// an open domain always carries a usable reciprocal
	a_recip_live: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (end_q > start_q)) |-> (recip_q != '0))
		else $error("open domain without reciprocal");

endmodule
`default_nettype wire

FILE: rtl/acal_ctrl.sv
// Controller state machine sequencing one request at a time.
`default_nettype none
module acal_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire acal_pkg::status_t status,
	output acal_pkg::cmd_t         cmd
);
	acal_pkg::state_t state_q;
	acal_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= acal_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			acal_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid)
					state_d = acal_pkg::ST_FILTER;
			end
			acal_pkg::ST_FILTER: begin
				cmd.filter = 1'b1;
				if (status.is_cmd)
					state_d = acal_pkg::ST_IDLE;
				else if (status.extreme)
					state_d = acal_pkg::ST_MUL_LO;
				else
					state_d = acal_pkg::ST_MAP;
			end
			acal_pkg::ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = acal_pkg::ST_MUL_HI;
			end
			acal_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = acal_pkg::ST_SPAN;
			end
			acal_pkg::ST_SPAN: begin
				if (status.span_ok) begin
					cmd.div_start = 1'b1;
					state_d       = acal_pkg::ST_DIV;
				end else begin
					state_d = acal_pkg::ST_MAP;
				end
			end
			acal_pkg::ST_DIV: begin
				if (status.div_done)
					state_d = acal_pkg::ST_MAP;
			end
			acal_pkg::ST_MAP: begin
				cmd.map = 1'b1;
				state_d = acal_pkg::ST_OUT;
			end
			acal_pkg::ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = acal_pkg::ST_IDLE;
				end
			end
			default: state_d = acal_pkg::ST_IDLE;
		endcase
	end

	a_accept_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == acal_pkg::ST_FILTER))
		else $error("accepted request not filtered next");

	a_div_waited: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == acal_pkg::ST_DIV))
		else $error("divider finished outside wait state");

endmodule
`default_nettype wire

FILE: rtl/analog_axis_calibrator.sv
// Top level of the analog axis calibrator: config registers, controller and datapath.
//
//  channel  dir  handshake      payload
//  sample   in   valid/ready    command, raw_sample[SAMPLE_BITS]
//  result   out  valid/ready    position[16], calib_low[16], calib_high[16]
//  cfg      in   cfg_wr_en      cfg_index[3], cfg_data[8]
//
// A sample with no new extreme goes through accept, filter, map and output.
// A new extreme also runs both deadzone multiplies and a span check; an open domain
// then waits on the 17-step serial divider that rebuilds the reciprocal; a closed
// domain skips it. A recalibrate is accepted and filtered and gives no result.
// Reset restores the control and calibration state at once; no clearing pass.
// A held result stalls only the final output step; the next request is taken
// while the previous result waits in the output register.
`default_nettype none
module analog_axis_calibrator #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	acal_sample_if.sink                            sample,
	acal_result_if.source                          result,
	input  wire logic                              cfg_wr_en,
	input  wire logic [acal_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [acal_pkg::CFG_DATA_W-1:0]   cfg_data
);
	acal_pkg::cfg_t    cfg_q;
	acal_pkg::cmd_t    cmd;
	acal_pkg::status_t status;

	// configuration registers: the user must write them only while idle; not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone_low    <= acal_pkg::DZ_LOW_RESET;
			cfg_q.deadzone_high   <= acal_pkg::DZ_HIGH_RESET;
			cfg_q.hysteresis_band <= acal_pkg::BAND_RESET;
			cfg_q.invert_axis     <= 1'b0;
			cfg_q.auto_calibrate  <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				acal_pkg::REG_DEADZONE_LOW:    cfg_q.deadzone_low    <= cfg_data;
				acal_pkg::REG_DEADZONE_HIGH:   cfg_q.deadzone_high   <= cfg_data;
				acal_pkg::REG_HYSTERESIS_BAND: cfg_q.hysteresis_band <= cfg_data;
				acal_pkg::REG_INVERT_AXIS:     cfg_q.invert_axis     <= cfg_data[0];
				acal_pkg::REG_AUTO_CALIBRATE:  cfg_q.auto_calibrate  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: one request in flight, divider wait dominates
	acal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// filter, extremes, deadzone domain, reciprocal and output register
	acal_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.status         (status),
		.in_command     (sample.command),
		.in_raw         (sample.raw_sample),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.out_position   (result.position),
		.out_calib_low  (result.calib_low),
		.out_calib_high (result.calib_high)
	);

endmodule
`default_nettype wire

FILE: bench/analog_axis_calibrator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the analog axis calibrator: directed and random traffic against a built-in axis model.
module analog_axis_calibrator_tb;

	localparam int SAMPLE_BITS  = 10;
	localparam int AXIS_W       = acal_pkg::AXIS_W;
	localparam int RECIP_W      = acal_pkg::RECIP_W;
	localparam int DZ_W         = acal_pkg::DZ_W;
	localparam int CFG_IDX_W    = acal_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W   = acal_pkg::CFG_DATA_W;
	localparam int RAW_MAX      = (1 << SAMPLE_BITS) - 1;
	localparam int PHASE_ITEMS  = 205;
	localparam int DRAIN_CYCLES = 40;    // longest request waits on the divider; recalibrate gives no result
	localparam int STALL_LIMIT  = 5000;  // cycles with no handshake on either channel
	localparam int HOLD_CYCLES  = 300;   // one long receiver back-off to fill the block

	typedef struct {
		bit             command;
		bit [SAMPLE_BITS-1:0] raw;
	} sample_req_t;

	typedef struct {
		bit [AXIS_W-1:0] position;
		bit [AXIS_W-1:0] calib_low;
		bit [AXIS_W-1:0] calib_high;
	} axis_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	acal_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	acal_result_if result_ch ();

	analog_axis_calibrator #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch.sink),
		.result    (result_ch.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Requests waiting to be driven, and results the axis model says must come out.
	sample_req_t  pending_reqs[$];
	axis_result_t expected_axis[$];

	// Axis model state, mirrored from the block's behaviour.
	acal_pkg::cfg_t    cur_cfg;
	bit [AXIS_W-1:0]   flt_val;
	bit [AXIS_W-1:0]   lo_seen;
	bit [AXIS_W-1:0]   hi_seen;
	bit [AXIS_W-1:0]   dom_start;
	bit [AXIS_W-1:0]   dom_end;
	bit [RECIP_W-1:0]  dom_recip;

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int req_count;
	int recal_count;
	int results_seen;
	int settings_count;
	int hold_left;
	bit hold_done;
	int stall_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- axis model

	// Rebuild the usable domain from the seen span, inset by the deadzone fractions.
	// A closed or reversed domain leaves the reciprocal alone.
	function automatic void rebuild_domain();
		bit [AXIS_W-1:0] span_w;
		bit [31:0]       inset_lo;
		bit [31:0]       inset_hi;
		span_w    = hi_seen - lo_seen;
		inset_lo  = (32'(span_w) * 32'(cur_cfg.deadzone_low)) >> 8;
		inset_hi  = (32'(span_w) * 32'(cur_cfg.deadzone_high)) >> 8;
		dom_start = lo_seen + inset_lo[AXIS_W-1:0];
		dom_end   = lo_seen + inset_hi[AXIS_W-1:0];
		if (dom_end > dom_start)
			dom_recip = RECIP_W'(32'd65536 / 32'(dom_end - dom_start));
	endfunction

	// Advance the model by one accepted request; queue the result it owes, if any.
	function automatic void calib_step(input bit command, input bit [SAMPLE_BITS-1:0] raw);
		int unsigned     raw_u;
		int unsigned     band;
		bit [AXIS_W-1:0] axis;
		bit [47:0]       scaled;
		axis_result_t    res;
		raw_u = raw;
		band  = cur_cfg.hysteresis_band;
		req_count++;
		if (command) begin
			// recalibrate: forget the extremes, preload the filter, no result
			lo_seen = acal_pkg::AXIS_MAX;
			hi_seen = '0;
			rebuild_domain();
			flt_val = AXIS_W'(raw_u);
			recal_count++;
			return;
		end
		if (raw_u > 32'(flt_val) + band)
			flt_val = AXIS_W'(raw_u - band);
		else if (raw_u + band < 32'(flt_val))
			flt_val = AXIS_W'(raw_u + band);
		axis = cur_cfg.invert_axis ? acal_pkg::AXIS_MAX - flt_val : flt_val;
		if (cur_cfg.auto_calibrate) begin
			// both extremes in one step: low first, then high, each with its own rebuild
			if (axis < lo_seen) begin
				lo_seen = axis;
				rebuild_domain();
			end
			if (axis > hi_seen) begin
				hi_seen = axis;
				rebuild_domain();
			end
		end
		if (axis <= dom_start)
			res.position = '0;
		else if (axis >= dom_end)
			res.position = acal_pkg::AXIS_MAX;
		else begin
			scaled       = 48'(axis - dom_start) * 48'(dom_recip);
			res.position = scaled[AXIS_W-1:0];
		end
		res.calib_low  = lo_seen;
		res.calib_high = hi_seen;
		expected_axis.push_back(res);
	endfunction

	// ---------------------------------------------------------------- helpers

	task automatic report_mismatch(input string what, input logic [AXIS_W-1:0] got,
		input logic [AXIS_W-1:0] want);
		fail_count++;
		if (fail_count <= 100)
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic void queue_req(input bit command, input int raw);
		sample_req_t req;
		req.command = command;
		req.raw     = SAMPLE_BITS'(raw);
		pending_reqs.push_back(req);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Writes every register; only called with the block drained.
	task automatic apply_settings(input int dz_lo, input int dz_hi, input int band,
		input bit inv, input bit autoc);
		write_reg(acal_pkg::REG_DEADZONE_LOW, CFG_DATA_W'(dz_lo));
		write_reg(acal_pkg::REG_DEADZONE_HIGH, CFG_DATA_W'(dz_hi));
		write_reg(acal_pkg::REG_HYSTERESIS_BAND, CFG_DATA_W'(band));
		write_reg(acal_pkg::REG_INVERT_AXIS, CFG_DATA_W'(inv));
		write_reg(acal_pkg::REG_AUTO_CALIBRATE, CFG_DATA_W'(autoc));
		cur_cfg.deadzone_low    = DZ_W'(dz_lo);
		cur_cfg.deadzone_high   = DZ_W'(dz_hi);
		cur_cfg.hysteresis_band = DZ_W'(band);
		cur_cfg.invert_axis     = inv;
		cur_cfg.auto_calibrate  = autoc;
		settings_count++;
	endtask

	// Drain: all requests taken, all results back, then let a trailing
	// recalibrate (which gives no result) finish before touching registers.
	task automatic drain_block();
		wait (pending_reqs.size() == 0 && !sample_ch.valid);
		wait (expected_axis.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- request driver

	always @(posedge clk or negedge arst_n) begin : drive_requests
		sample_req_t nxt;
		if (!arst_n) begin
			sample_ch.valid      <= 1'b0;
			sample_ch.command    <= 1'b0;
			sample_ch.raw_sample <= '0;
		end else begin
			// handshake seen on pre-edge values: the held request is taken now
			if (sample_ch.valid && sample_ch.ready)
				calib_step(sample_ch.command, sample_ch.raw_sample);
			if (!sample_ch.valid || sample_ch.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_reqs.pop_front();
					sample_ch.valid      <= 1'b1;
					sample_ch.command    <= nxt.command;
					sample_ch.raw_sample <= nxt.raw;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- result monitor

	always @(posedge clk or negedge arst_n) begin : check_results
		axis_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_axis.size() == 0) begin
					report_mismatch("result with nothing outstanding", result_ch.position, '0);
				end else begin
					want = expected_axis.pop_front();
					if (result_ch.position !== want.position)
						report_mismatch("position", result_ch.position, want.position);
					if (result_ch.calib_low !== want.calib_low)
						report_mismatch("calib_low", result_ch.calib_low, want.calib_low);
					if (result_ch.calib_high !== want.calib_high)
						report_mismatch("calib_high", result_ch.calib_high, want.calib_high);
				end
			end
			// One long back-off once a backlog exists, so the output register fills
			// and the block has to push back on the request side.
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!hold_done && results_seen >= 300 && pending_reqs.size() > 16) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("** analog_axis_calibrator: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		int roll;
		int walk;
		int p;
		int k;

		// everything known from time zero
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.command    = 1'b0;
		sample_ch.raw_sample = '0;
		result_ch.ready      = 1'b0;
		stall_cycles         = 0;
		send_idle_pct        = 37;
		recv_idle_pct        = 77;

		// model at reset
		cur_cfg.deadzone_low    = acal_pkg::DZ_LOW_RESET;
		cur_cfg.deadzone_high   = acal_pkg::DZ_HIGH_RESET;
		cur_cfg.hysteresis_band = acal_pkg::BAND_RESET;
		cur_cfg.invert_axis     = 1'b0;
		cur_cfg.auto_calibrate  = 1'b1;
		flt_val   = '0;
		lo_seen   = acal_pkg::AXIS_MAX;
		hi_seen   = '0;
		dom_start = acal_pkg::AXIS_MAX;
		dom_end   = acal_pkg::AXIS_MAX;
		dom_recip = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset registers. Full-scale jumps, a step inside the
		// hysteresis band, recalibrate preloading the top code.
		queue_req(0, 0);
		queue_req(0, RAW_MAX);
		queue_req(0, RAW_MAX - 1);
		queue_req(0, 512);
		queue_req(1, RAW_MAX);
		queue_req(0, RAW_MAX);
		queue_req(0, 0);

		// No band, mirrored axis, widest domain.
		drain_block();
		apply_settings(0, 255, 0, 1'b1, 1'b1);
		queue_req(0, 0);
		queue_req(0, 1);
		queue_req(0, RAW_MAX);
		queue_req(0, RAW_MAX - 1);
		queue_req(1, 0);
		queue_req(0, 700);
		queue_req(0, 300);

		// Widest band, deadzones reversed: domain treated as empty.
		drain_block();
		apply_settings(255, 0, 255, 1'b0, 1'b1);
		queue_req(1, 0);
		queue_req(0, RAW_MAX);
		queue_req(0, 0);
		queue_req(0, 600);
		queue_req(0, RAW_MAX);

		// Tracking off, equal deadzones: extremes frozen, zero-width domain.
		drain_block();
		apply_settings(128, 128, 3, 1'b0, 1'b0);
		queue_req(0, 512);
		queue_req(0, 0);
		queue_req(0, RAW_MAX);
		queue_req(1, 512);

		// Random phases. Each opens with a recalibrate, then mostly a wandering
		// stick with full sweeps, jitter near the filter and the odd recalibrate.
		for (p = 0; p < 6; p++) begin
			drain_block();
			case (p)
				0: apply_settings(acal_pkg::DZ_LOW_RESET, acal_pkg::DZ_HIGH_RESET,
					acal_pkg::BAND_RESET, 1'b0, 1'b1);
				1: apply_settings(0, 255, 0, 1'b0, 1'b1);
				2: apply_settings(255, 255, 255, 1'b1, 1'b1);
				3: apply_settings($urandom_range(0, 60), $urandom_range(190, 255),
					$urandom_range(0, 255), 1'($urandom_range(0, 1)), 1'b1);
				4: apply_settings(200, 40, 2, 1'b1, 1'b1);
				default: apply_settings($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 16), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
			// receiver-heavy idling, then sender-heavy, then none
			if (p < 2) begin
				send_idle_pct = 37;
				recv_idle_pct = 77;
			end else if (p < 4) begin
				send_idle_pct = 77;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			walk = $urandom_range(0, RAW_MAX);
			queue_req(1, walk);
			for (k = 1; k < PHASE_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 4) begin
					queue_req(1, $urandom_range(0, RAW_MAX));
				end else if (roll < 60) begin
					walk = walk + int'($urandom_range(0, 80)) - 40;
					if (walk < 0) walk = 0;
					if (walk > RAW_MAX) walk = RAW_MAX;
					queue_req(0, walk);
				end else if (roll < 85) begin
					queue_req(0, $urandom_range(0, RAW_MAX));
				end else if (roll < 93) begin
					queue_req(0, (roll % 2) ? RAW_MAX : 0);
				end else begin
					// small wiggle, mostly inside the band
					queue_req(0, (walk + int'($urandom_range(0, 6)) - 3) & RAW_MAX);
				end
			end
		end

		// Let everything come out, then DRAIN_CYCLES of quiet for strays.
		wait (pending_reqs.size() == 0 && !sample_ch.valid);
		wait (expected_axis.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_axis.size() != 0)
			report_mismatch("results never delivered", '0, 16'(expected_axis.size()));

		$display("Ran %0d requests (%0d recalibrations) giving %0d results", req_count,
			recal_count, results_seen);
		$display("across %0d register settings, with a %0d-cycle output back-off; %0d mismatches",
			settings_count, HOLD_CYCLES, fail_count);
		if (fail_count == 0)
			$display("** analog_axis_calibrator: PASSED **");
		else
			$display("** analog_axis_calibrator: FAILED **");
		$finish;
	end

endmodule
